// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- src/ceu_pkg.sv -----
// Types and constants of the C escape decoder.
`default_nettype none

package ceu_pkg;

	// Character codes that the decoder looks for.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_7     = 8'h37;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_V     = 8'h76;

	// Control bytes produced by the named escapes.
	localparam logic [7:0] BY_BEL   = 8'd7;
	localparam logic [7:0] BY_BS    = 8'd8;
	localparam logic [7:0] BY_HT    = 8'd9;
	localparam logic [7:0] BY_LF    = 8'd10;
	localparam logic [7:0] BY_VT    = 8'd11;
	localparam logic [7:0] BY_FF    = 8'd12;
	localparam logic [7:0] BY_CR    = 8'd13;

	// Escape accumulator limits.
	localparam logic [8:0] VAL_SATURATED = 9'd256;
	localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

	// Result queue geometry.
	localparam int OQ_AW    = 2;
	localparam int OQ_DEPTH = 1 << OQ_AW;

	// One queued result beat.
	typedef struct packed {
		logic [7:0] data;
		logic       term;
		logic       last;
	} res_t;

endpackage

`default_nettype wire

// ----- src/c_escape_unescape_core.sv -----
// Top level of the C string escape decoder.
//
// Channel  Dir  tdata               tuser          tlast
// s_*      in   [7:0] in_char       -              -
// m_*      out  [7:0] out_byte      is_terminator  last_of_run
//
// A character accepted into the input stage is decoded there against the escape state, and its
// results are written from that registered stage into the result queue, whose head drives m_*.
// One character is accepted per cycle while the queue has room; a character with two results
// adds a beat to the queue, so under a steady drain the input stalls once the queue has filled.
// The four-entry result queue sets how long s_tready stays high while m_tready is low.
// arst_n clears the escape state, the input stage and the result queue.
`default_nettype none

module c_escape_unescape_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] in_char
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic      [7:0] m_tdata,   // [7:0] out_byte
	output logic            m_tuser,   // [0] is_terminator
	output logic            m_tlast    // last_of_run
);

	typedef enum logic [2:0] {
		MODE_PLAIN  = 3'd0,
		MODE_ESC    = 3'd1,
		MODE_XSTART = 3'd2,
		MODE_HEX    = 3'd3,
		MODE_OCT    = 3'd4
	} mode_t;

	localparam int CNT_W = ceu_pkg::OQ_AW + 1;

	// Input stage.
	logic                 valid_s1;
	logic [7:0]           char_s1;

	// Escape state.
	mode_t                mode_q;
	logic [8:0]           value_q;
	logic                 ovf_q;
	logic [1:0]           cnt_q;

	// Result queue.
	ceu_pkg::res_t        fifo_q [ceu_pkg::OQ_DEPTH];
	logic [ceu_pkg::OQ_AW-1:0] wr_ptr_q;
	logic [ceu_pkg::OQ_AW-1:0] rd_ptr_q;
	logic [CNT_W-1:0]     count_q;

	// Decode results.
	mode_t                mode_d;
	logic [8:0]           value_d;
	logic                 ovf_d;
	logic [1:0]           cnt_d;
	logic                 pre_v;
	logic [7:0]           pre_b;
	logic                 pl_v;
	logic [7:0]           pl_b;
	logic                 pl_term;
	logic                 do_plain;
	logic [1:0]           need;
	ceu_pkg::res_t        ent0;
	ceu_pkg::res_t        ent1;

	logic                 is_dec;
	logic                 is_oct;
	logic                 is_hex;
	logic [3:0]           hex_d;
	logic [12:0]          hex_acc;
	logic [8:0]           oct_acc;
	logic [1:0]           cnt_inc;

	logic                 pop;
	logic                 adv;
	logic [CNT_W:0]       room_lhs;
	logic [CNT_W:0]       room_rhs;

	// Character classes and digit values.
	always_comb begin
		is_dec = char_s1 inside {[ceu_pkg::CH_0:ceu_pkg::CH_9]};
		is_oct = char_s1 inside {[ceu_pkg::CH_0:ceu_pkg::CH_7]};
		is_hex = 1'b1;
		hex_d  = 4'd0;
		if (is_dec) begin
			hex_d = 4'(char_s1 - ceu_pkg::CH_0);
		end else if (char_s1 inside {[ceu_pkg::CH_LA:ceu_pkg::CH_LF]}) begin
			hex_d = 4'(char_s1 - ceu_pkg::CH_LA + 8'd10);
		end else if (char_s1 inside {[ceu_pkg::CH_UA:ceu_pkg::CH_UF]}) begin
			hex_d = 4'(char_s1 - ceu_pkg::CH_UA + 8'd10);
		end else begin
			is_hex = 1'b0;
		end
		hex_acc = {value_q, 4'b0000} + {9'd0, hex_d};
		oct_acc = {value_q[5:0], 3'b000} + {6'd0, char_s1[2:0]};
		cnt_inc = cnt_q + 2'd1;
	end

	// Decode of the character in the input stage against the escape state.
	always_comb begin
		mode_d   = mode_q;
		value_d  = value_q;
		ovf_d    = ovf_q;
		cnt_d    = cnt_q;
		pre_v    = 1'b0;
		pre_b    = 8'd0;
		do_plain = 1'b0;
		case (mode_q)
			MODE_ESC: begin
				mode_d = MODE_PLAIN;
				pre_v  = 1'b1;
				case (char_s1)
					ceu_pkg::CH_LA:  pre_b = ceu_pkg::BY_BEL;
					ceu_pkg::CH_B:   pre_b = ceu_pkg::BY_BS;
					ceu_pkg::CH_LF:  pre_b = ceu_pkg::BY_FF;
					ceu_pkg::CH_N:   pre_b = ceu_pkg::BY_LF;
					ceu_pkg::CH_R:   pre_b = ceu_pkg::BY_CR;
					ceu_pkg::CH_T:   pre_b = ceu_pkg::BY_HT;
					ceu_pkg::CH_V:   pre_b = ceu_pkg::BY_VT;
					ceu_pkg::CH_X: begin
						pre_v  = 1'b0;
						mode_d = MODE_XSTART;
					end
					ceu_pkg::CH_NUL: begin
						// Trailing backslash: the backslash, then the terminator.
						pre_b    = ceu_pkg::CH_BSL;
						do_plain = 1'b1;
					end
					default: begin
						if (is_oct) begin
							pre_v   = 1'b0;
							value_d = {6'd0, char_s1[2:0]};
							cnt_d   = 2'd1;
							mode_d  = MODE_OCT;
						end else begin
							pre_b = char_s1;
						end
					end
				endcase
			end
			MODE_XSTART: begin
				if (is_dec) begin
					value_d = {5'd0, hex_d};
					ovf_d   = 1'b0;
					mode_d  = MODE_HEX;
				end else begin
					// Backslash x without a decimal digit gives a plain x.
					pre_v    = 1'b1;
					pre_b    = ceu_pkg::CH_X;
					do_plain = 1'b1;
				end
			end
			MODE_HEX: begin
				if (is_hex) begin
					if (ovf_q || (hex_acc[12:8] != 5'd0)) begin
						ovf_d   = 1'b1;
						value_d = ceu_pkg::VAL_SATURATED;
					end else begin
						value_d = hex_acc[8:0];
					end
				end else begin
					pre_v    = !ovf_q && !value_q[8];
					pre_b    = value_q[7:0];
					ovf_d    = 1'b0;
					value_d  = 9'd0;
					do_plain = 1'b1;
				end
			end
			MODE_OCT: begin
				if (is_oct && (cnt_q < ceu_pkg::OCT_MAX_DIGITS)) begin
					value_d = oct_acc;
					cnt_d   = cnt_inc;
					if (cnt_inc == ceu_pkg::OCT_MAX_DIGITS) begin
						pre_v   = !oct_acc[8];
						pre_b   = oct_acc[7:0];
						value_d = 9'd0;
						cnt_d   = 2'd0;
						mode_d  = MODE_PLAIN;
					end
				end else begin
					pre_v    = !value_q[8];
					pre_b    = value_q[7:0];
					value_d  = 9'd0;
					cnt_d    = 2'd0;
					do_plain = 1'b1;
				end
			end
			default: begin
				do_plain = 1'b1;
			end
		endcase

		// Plain text handling, also for the character that ends an escape.
		pl_v    = 1'b0;
		pl_b    = 8'd0;
		pl_term = 1'b0;
		if (do_plain) begin
			mode_d = MODE_PLAIN;
			if (char_s1 == ceu_pkg::CH_NUL) begin
				pl_v    = 1'b1;
				pl_term = 1'b1;
			end else if (char_s1 == ceu_pkg::CH_BSL) begin
				mode_d = MODE_ESC;
			end else begin
				pl_v = 1'b1;
				pl_b = char_s1;
			end
		end
	end

	// Order the results of this character into queue entries.
	always_comb begin
		need = {1'b0, pre_v} + {1'b0, pl_v};
		ent1 = '{data: pl_b, term: pl_term, last: 1'b1};
		if (pre_v) begin
			ent0 = '{data: pre_b, term: 1'b0, last: !pl_v};
		end else begin
			ent0 = ent1;
		end
	end

	// Handshakes: the input stage moves on when the queue has room for its results.
	always_comb begin
		pop      = m_tvalid && m_tready;
		room_lhs = {1'b0, count_q} + {{(CNT_W - 1){1'b0}}, need};
		room_rhs = (CNT_W + 1)'(ceu_pkg::OQ_DEPTH) + {{CNT_W{1'b0}}, pop};
		adv      = valid_s1 && (room_lhs <= room_rhs);
		s_tready = !valid_s1 || adv;
	end

	// Output beat from the head of the queue.
	always_comb begin
		m_tvalid = (count_q != '0);
		m_tdata  = fifo_q[rd_ptr_q].data;
		m_tuser  = fifo_q[rd_ptr_q].term;
		m_tlast  = fifo_q[rd_ptr_q].last;
	end

	// Input stage, escape state and result queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			char_s1  <= 8'h00;
			mode_q   <= MODE_PLAIN;
			value_q  <= 9'd0;
			ovf_q    <= 1'b0;
			cnt_q    <= 2'd0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
				char_s1  <= s_tdata;
			end
			if (adv) begin
				mode_q  <= mode_d;
				value_q <= value_d;
				ovf_q   <= ovf_d;
				cnt_q   <= cnt_d;
				if (need != 2'd0) begin
					fifo_q[wr_ptr_q] <= ent0;
				end
				if (need == 2'd2) begin
					fifo_q[wr_ptr_q + ceu_pkg::OQ_AW'(1)] <= ent1;
				end
				wr_ptr_q <= wr_ptr_q + ceu_pkg::OQ_AW'(need);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + ceu_pkg::OQ_AW'(1);
			end
			count_q <= count_q + (adv ? CNT_W'(need) : CNT_W'(0)) - CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

// ----- src/ceu_checker.sv -----
// Port-level checker of the C escape decoder and its bind to the top level.
`default_nettype none

`include "assert_macros.svh"

module ceu_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic [7:0] s_tdata,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       m_tuser,
	input wire logic       m_tlast
);

	logic s_stall;
	logic m_stall;
	logic m_term;

	assign s_stall = s_tvalid && !s_tready;
	assign m_stall = m_tvalid && !m_tready;
	assign m_term  = m_tvalid && m_tuser;

	// A terminator beat carries a zero byte.
	`ASSERT_SAME(a_term_zero, clk, arst_n, m_term, m_tdata == ceu_pkg::CH_NUL)
	// A terminator is always the last beat of its character.
	`ASSERT_SAME(a_term_last, clk, arst_n, m_term, m_tlast)
	// A stalled output beat stays offered.
	`ASSERT_NEXT(a_m_hold, clk, arst_n, m_stall, m_tvalid)
	// A stalled output beat keeps its payload.
	`ASSERT_NEXT(a_m_stable, clk, arst_n, m_stall,
		$stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
	// A stalled input beat stays offered with the same character.
	`ASSERT_NEXT(a_s_hold, clk, arst_n, s_stall, s_tvalid && $stable(s_tdata))

endmodule

bind c_escape_unescape_core ceu_checker u_ceu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire
